// File: rtl/core/hmsf_pkg.sv
// ============================================================================
// hmsf_pkg
// Shared types and constants for the halfword memory with screen flag.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package hmsf_pkg;

  // Field widths of the stream items.
  localparam int CMD_W   = 3;
  localparam int ADDR_W  = 17;
  localparam int DATA_W  = 32;
  localparam int HALF_W  = 16;
  localparam int BASE_W  = 16;

  // Packed widths on the stream buses; tdata is filled up to whole bytes.
  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 32;
  localparam int M_TUSER_W = 2;

  // Default memory depth in 16-bit entries.
  localparam int MEM_DEPTH_DEFAULT = 65536;

  // Reset value of the screen base register.
  localparam logic [BASE_W-1:0] SCREEN_BASE_RESET = 16'hF000;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD_WORD  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STORE_WORD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_HALF  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STORE_HALF = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

  // Decoded access kind for one command.
  typedef struct packed {
    logic load;
    logic store;
    logic word;
    logic clear;
  } hmsf_op_t;

  // Decode a command code into its access kind.
  function automatic hmsf_op_t decode_cmd(input logic [CMD_W-1:0] cmd);
    hmsf_op_t op;
    op = '0;
    case (cmd)
      CMD_LOAD_WORD: begin
        op.load = 1'b1;
        op.word = 1'b1;
      end
      CMD_STORE_WORD: begin
        op.store = 1'b1;
        op.word  = 1'b1;
      end
      CMD_LOAD_HALF: begin
        op.load = 1'b1;
      end
      CMD_STORE_HALF: begin
        op.store = 1'b1;
      end
      CMD_CLEAR: begin
        op.clear = 1'b1;
      end
      default: begin
        op = '0;
      end
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/hmsf_ram.sv
// ============================================================================
// hmsf_ram
// Generic single-port RAM with a registered read and no reset.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hmsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One address per cycle: a write, a read that lands in rdata, or both.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/halfword_memory_with_screen_flag_core.sv
// ============================================================================
// halfword_memory_with_screen_flag_core
// Memory of 16-bit entries with word and half accesses and a screen flag.
// ============================================================================
//
// Channel   Direction  Contents
// s_*       in         tuser: command; tdata: address, write_data
// m_*       out        tdata: read_data; tuser: address_error, refresh_pending
// cfg_*     in         cfg_data: screen_base
//
// An item can be accepted every cycle while the output does not stall. Its
// result passes through the read stage into the result register, which
// drives the result handshake.
// The entries sit in an even bank and an odd bank, so the two halves of a
// word access are read or written in the same cycle at one port each.
// Reset clears the refresh flag and the pipeline and sets screen_base to
// its reset value; the memory content is left as it is.
// A stalled output holds one more item in the read stage before s_tready
// falls.
//
`timescale 1ns / 1ps
`default_nettype none

module halfword_memory_with_screen_flag_core #(
  parameter int MEM_DEPTH = hmsf_pkg::MEM_DEPTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Input items.
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // [16:0] address, [48:17] write_data, [55:49] zero
  input  wire logic [hmsf_pkg::S_TDATA_W-1:0] s_tdata,
  // [2:0] command
  input  wire logic [hmsf_pkg::CMD_W-1:0]     s_tuser,
  // Result items.
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // [31:0] read_data
  output logic      [hmsf_pkg::M_TDATA_W-1:0] m_tdata,
  // [0] address_error, [1] refresh_pending
  output logic      [hmsf_pkg::M_TUSER_W-1:0] m_tuser,
  // Configuration write.
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [hmsf_pkg::BASE_W-1:0]    cfg_data
);

  import hmsf_pkg::*;

  // Bank geometry: even entries in one bank, odd entries in the other.
  localparam int EV_DEPTH = (MEM_DEPTH + 1) / 2;
  localparam int OD_DEPTH = MEM_DEPTH / 2;
  localparam int EV_AW    = (EV_DEPTH > 1) ? $clog2(EV_DEPTH) : 1;
  localparam int OD_AW    = (OD_DEPTH > 1) ? $clog2(OD_DEPTH) : 1;
  localparam logic [ADDR_W:0] DEPTH_X = (ADDR_W + 1)'(MEM_DEPTH);

  // Registers.
  logic [BASE_W-1:0] screen_base;
  logic              dirty;
  logic              s1_valid;
  logic              s1_load;
  logic              s1_word;
  logic              s1_odd;
  logic              s1_err;
  logic              s1_flag;
  logic              out_valid;
  logic [DATA_W-1:0] out_data;
  logic              out_err;
  logic              out_flag;

  // Combinational signals.
  logic              s_accept;
  logic              s1_move;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;
  logic [ADDR_W:0]   addr_x;
  logic [ADDR_W:0]   addr_p1;
  logic [ADDR_W:0]   base_x;
  hmsf_op_t          op;
  logic              in_range;
  logic              err;
  logic              odd;
  logic              ev_use;
  logic              od_use;
  logic              ev_we;
  logic              ev_re;
  logic              od_we;
  logic              od_re;
  logic [HALF_W-1:0] ev_wdata;
  logic [HALF_W-1:0] od_wdata;
  logic [HALF_W-1:0] ev_rdata;
  logic [HALF_W-1:0] od_rdata;
  logic [HALF_W-1:0] half_sel;
  logic              dirty_next;
  logic [DATA_W-1:0] rd_next;

  // Unpack the input item.
  assign address    = s_tdata[ADDR_W-1:0];
  assign write_data = s_tdata[ADDR_W +: DATA_W];
  assign op         = decode_cmd(s_tuser);

  // Handshakes.
  assign s1_move   = s1_valid && (!out_valid || m_tready);
  assign s_tready  = !s1_valid || s1_move;
  assign s_accept  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Range check and bank selection.
  assign addr_x   = {1'b0, address};
  assign addr_p1  = addr_x + (ADDR_W + 1)'(1);
  assign base_x   = (ADDR_W + 1)'(screen_base);
  assign odd      = address[0];
  assign in_range = op.word ? (addr_p1 < DEPTH_X) : (addr_x < DEPTH_X);
  assign err      = (op.load || op.store) && !in_range;
  assign ev_use   = op.word || !odd;
  assign od_use   = op.word || odd;
  assign ev_we    = s_accept && op.store && in_range && ev_use;
  assign od_we    = s_accept && op.store && in_range && od_use;
  assign ev_re    = s_accept && op.load && in_range && ev_use;
  assign od_re    = s_accept && op.load && in_range && od_use;

  // The high half of a word goes to the entry at the address itself.
  assign ev_wdata = (op.word && !odd) ? write_data[DATA_W-1:HALF_W]
                                      : write_data[HALF_W-1:0];
  assign od_wdata = (op.word && odd) ? write_data[DATA_W-1:HALF_W]
                                     : write_data[HALF_W-1:0];

  // Refresh flag after this item.
  always_comb begin
    dirty_next = dirty;
    if (op.clear) begin
      dirty_next = 1'b0;
    end else if (op.store && in_range) begin
      if (op.word) begin
        if (addr_p1 >= base_x) begin
          dirty_next = 1'b1;
        end
      end else if (addr_x >= base_x) begin
        dirty_next = 1'b1;
      end
    end
  end

  hmsf_ram #(
    .WIDTH (HALF_W),
    .DEPTH (EV_DEPTH)
  ) u_even (
    .clk   (clk),
    .we    (ev_we),
    .re    (ev_re),
    .addr  (addr_p1[EV_AW:1]),
    .wdata (ev_wdata),
    .rdata (ev_rdata)
  );

  hmsf_ram #(
    .WIDTH (HALF_W),
    .DEPTH (OD_DEPTH)
  ) u_odd (
    .clk   (clk),
    .we    (od_we),
    .re    (od_re),
    .addr  (addr_x[OD_AW:1]),
    .wdata (od_wdata),
    .rdata (od_rdata)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_base <= SCREEN_BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      screen_base <= cfg_data;
    end
  end

  // Refresh flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      dirty <= 1'b0;
    end else if (s_accept) begin
      dirty <= dirty_next;
    end
  end

  // Read stage: item details while the banks deliver their data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_load <= op.load && in_range;
      s1_word <= op.word;
      s1_odd  <= odd;
      s1_err  <= err;
      s1_flag <= dirty_next;
    end
  end

  // Assemble the loaded value from the two banks.
  assign half_sel = s1_odd ? od_rdata : ev_rdata;

  always_comb begin
    rd_next = '0;
    if (s1_load) begin
      if (s1_word) begin
        rd_next = s1_odd ? {od_rdata, ev_rdata} : {ev_rdata, od_rdata};
      end else begin
        rd_next = {{(DATA_W - HALF_W){half_sel[HALF_W-1]}}, half_sel};
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data <= rd_next;
      out_err  <= s1_err;
      out_flag <= s1_flag;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = {out_flag, out_err};

`ifndef SYNTHESIS
  // An address error never carries loaded data.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("address error with nonzero read data");

  // Nothing enters while both stages are full and the output stalls.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !m_tready |-> !s_tready)
    else $error("item accepted into a full pipeline");

  // The banks are written only by an accepted in-range store.
  assert property (@(posedge clk) disable iff (rst)
    ev_we || od_we |-> s_accept && op.store && !err)
    else $error("bank write without an accepted store");

  // A clear command leaves the flag low.
  assert property (@(posedge clk) disable iff (rst)
    s_accept && op.clear |=> !dirty)
    else $error("refresh flag set after clear");

  // A read stage advancing always loads the result register.
  assert property (@(posedge clk) disable iff (rst)
    s1_move |=> out_valid)
    else $error("result lost between stages");
`endif

endmodule

`default_nettype wire

// File: test/halfword_memory_with_screen_flag_core_tb.sv
// ============================================================================
// halfword_memory_with_screen_flag_core_tb
// Checks word and half loads and stores, address errors and the sticky
// screen refresh flag against a behavioral memory image kept in the bench.
// Directed items cover the edges of memory and the screen base; random
// traffic runs under three idling patterns with a new screen base each time.
// ============================================================================
`timescale 1ns / 1ps

module halfword_memory_with_screen_flag_core_tb;

  import hmsf_pkg::*;

  localparam int MEM_ENTRIES = MEM_DEPTH_DEFAULT;
  localparam int ADDR_TOP    = (1 << ADDR_W) - 1;
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;

  // One result item as the block should deliver it.
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              address_error;
    logic              refresh_pending;
  } access_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [CMD_W-1:0]     s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [BASE_W-1:0]    cfg_data = '0;

  // Behavioral copy of the memory and the screen flag.
  logic [HALF_W-1:0] mem_image [MEM_ENTRIES];
  bit                entry_written [MEM_ENTRIES];
  int                written_entries [$];
  logic              refresh_flag = 1'b0;
  logic [BASE_W-1:0] screen_base_shadow = SCREEN_BASE_RESET;

  access_result_t results_due [$];
  access_result_t oldest_due;
  int             mismatches = 0;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;

  halfword_memory_with_screen_flag_core uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Marks one entry as holding a defined value, so loads may target it.
  function automatic void note_written(input int entry);
    if (!entry_written[entry]) begin
      entry_written[entry] = 1'b1;
      written_entries.push_back(entry);
    end
  endfunction

  // Applies one access to the memory image and returns the result it causes.
  function automatic access_result_t compute_access(input logic [CMD_W-1:0] cmd,
                                                    input logic [ADDR_W-1:0] addr,
                                                    input logic [DATA_W-1:0] data);
    access_result_t r;
    int a;
    logic [HALF_W-1:0] h;
    r = '0;
    a = int'(addr);
    case (cmd)
      CMD_LOAD_WORD: begin
        if (a + 1 < MEM_ENTRIES) r.read_data = {mem_image[a], mem_image[a + 1]};
        else r.address_error = 1'b1;
      end
      CMD_STORE_WORD: begin
        if (a + 1 < MEM_ENTRIES) begin
          mem_image[a]     = data[31:16];
          mem_image[a + 1] = data[15:0];
          note_written(a);
          note_written(a + 1);
          // The second entry is the higher one, so it alone decides the flag.
          if (a + 1 >= int'(screen_base_shadow)) refresh_flag = 1'b1;
        end else begin
          r.address_error = 1'b1;
        end
      end
      CMD_LOAD_HALF: begin
        if (a < MEM_ENTRIES) begin
          h = mem_image[a];
          r.read_data = {{HALF_W{h[HALF_W-1]}}, h};
        end else begin
          r.address_error = 1'b1;
        end
      end
      CMD_STORE_HALF: begin
        if (a < MEM_ENTRIES) begin
          mem_image[a] = data[15:0];
          note_written(a);
          if (a >= int'(screen_base_shadow)) refresh_flag = 1'b1;
        end else begin
          r.address_error = 1'b1;
        end
      end
      CMD_CLEAR: begin
        refresh_flag = 1'b0;
      end
      default: begin
      end
    endcase
    r.refresh_pending = refresh_flag;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Sends one access item and records its expected result on acceptance.
  task automatic send_access(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W - ADDR_W - DATA_W){1'b0}}, data, addr};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    results_due.push_back(compute_access(cmd, addr, data));
  endtask

  // Drops the input valid and waits until every result has come back.
  task automatic settle_pipeline();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_screen_base(input logic [BASE_W-1:0] value);
    settle_pipeline();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    screen_base_shadow = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver side: stall at the rate of the current phase.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each delivered result with the oldest one awaited.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        report_mismatch("result with none awaited", m_tdata, '0);
      end else begin
        oldest_due = results_due.pop_front();
        if (m_tdata !== oldest_due.read_data)
          report_mismatch("read_data", m_tdata, oldest_due.read_data);
        if (m_tuser[0] !== oldest_due.address_error)
          report_mismatch("address_error", m_tuser[0], oldest_due.address_error);
        if (m_tuser[1] !== oldest_due.refresh_pending)
          report_mismatch("refresh_pending", m_tuser[1], oldest_due.refresh_pending);
      end
    end
  end

  // Edges of the data, both halves of memory and every command.
  task automatic test_directed();
    send_access(CMD_STORE_WORD, 17'h00000, 32'h0000_0000);
    send_access(CMD_LOAD_WORD, 17'h00000, 32'hFFFF_FFFF);
    send_access(CMD_STORE_WORD, 17'h00002, 32'hFFFF_FFFF);
    send_access(CMD_LOAD_WORD, 17'h00002, 32'h0000_0000);
    send_access(CMD_LOAD_HALF, 17'h00003, 32'h0000_0000);
    // Half stores keep only the low half of the data.
    send_access(CMD_STORE_HALF, 17'h00004, 32'h1234_7FFF);
    send_access(CMD_STORE_HALF, 17'h00005, 32'hFFFF_8000);
    send_access(CMD_LOAD_HALF, 17'h00004, 32'h0000_0000);
    send_access(CMD_LOAD_HALF, 17'h00005, 32'h0000_0000);
    send_access(CMD_LOAD_WORD, 17'h00004, 32'h0000_0000);
    // A word store just below the screen, then one whose second entry alone reaches it.
    send_access(CMD_STORE_WORD, 17'h0EFFE, 32'h1357_9BDF);
    send_access(CMD_STORE_WORD, 17'h0EFFF, 32'h2468_ACE0);
    send_access(CMD_CLEAR, 17'h1FFFF, 32'hFFFF_FFFF);
    send_access(CMD_STORE_HALF, 17'h0EFFF, 32'h0000_ABCD);
    send_access(CMD_STORE_HALF, 17'h0F000, 32'h0000_5555);
    // Last word and last entry in memory, then accesses that run past the end.
    send_access(CMD_STORE_WORD, 17'h0FFFE, 32'hA5A5_5A5A);
    send_access(CMD_LOAD_WORD, 17'h0FFFE, 32'h0000_0000);
    send_access(CMD_LOAD_HALF, 17'h0FFFF, 32'h0000_0000);
    send_access(CMD_STORE_WORD, 17'h0FFFF, 32'hDEAD_BEEF);
    send_access(CMD_LOAD_WORD, 17'h0FFFF, 32'h0000_0000);
    send_access(CMD_STORE_HALF, 17'h10000, 32'h0000_FFFF);
    send_access(CMD_LOAD_HALF, 17'h1FFFF, 32'h0000_0000);
    // Unused commands leave the flag as it is, set and then cleared.
    send_access(3'd5, 17'h0ABCD, 32'h8000_0001);
    send_access(CMD_CLEAR, 17'h00000, 32'h0000_0000);
    send_access(3'd6, 17'h1FFFF, 32'hFFFF_FFFF);
    send_access(3'd7, 17'h00001, 32'h0000_0000);
  endtask

  // Screen base at both extremes and in the middle.
  task automatic test_screen_base();
    write_screen_base(16'h0000);
    send_access(CMD_STORE_HALF, 17'h00000, 32'h0000_0001);
    send_access(CMD_CLEAR, 17'h00000, 32'h0000_0000);
    send_access(CMD_STORE_WORD, 17'h1FFFF, 32'h1111_2222);
    send_access(CMD_STORE_WORD, 17'h0000A, 32'h3333_4444);
    write_screen_base(16'hFFFF);
    send_access(CMD_CLEAR, 17'h00000, 32'h0000_0000);
    send_access(CMD_STORE_HALF, 17'h0FFFE, 32'h0000_7777);
    send_access(CMD_STORE_WORD, 17'h0FFFD, 32'h8888_9999);
    send_access(CMD_STORE_WORD, 17'h0FFFE, 32'hAAAA_BBBB);
    send_access(CMD_CLEAR, 17'h00000, 32'h0000_0000);
    send_access(CMD_STORE_HALF, 17'h0FFFF, 32'h0000_CCCC);
    send_access(CMD_LOAD_WORD, 17'h0FFFE, 32'h0000_0000);
    write_screen_base(16'h8000);
    send_access(CMD_CLEAR, 17'h00000, 32'h0000_0000);
    send_access(CMD_STORE_WORD, 17'h07FFE, 32'h0102_0304);
    send_access(CMD_STORE_WORD, 17'h07FFF, 32'h0506_0708);
    write_screen_base(SCREEN_BASE_RESET);
  endtask

  // One random item; loads only target entries that hold a value, or addresses past the end.
  task automatic random_access();
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    int pick;
    int zone;
    int spot;
    int e;
    data = $urandom;
    case ($urandom_range(7))
      0: begin
        data = '0;
      end
      1: begin
        data = '1;
      end
      default: begin
      end
    endcase
    // Stores mostly hit a small window and the area around the screen base.
    zone = $urandom_range(99);
    if (zone < 40) begin
      addr = ADDR_W'($urandom_range(255));
    end else if (zone < 70) begin
      spot = int'(screen_base_shadow) + int'($urandom_range(127)) - 64;
      if (spot < 0) spot = 0;
      if (spot > MEM_ENTRIES - 1) spot = MEM_ENTRIES - 1;
      addr = ADDR_W'(spot);
    end else if (zone < 85) begin
      addr = ADDR_W'($urandom_range(MEM_ENTRIES - 1));
    end else begin
      addr = ADDR_W'($urandom_range(ADDR_TOP, MEM_ENTRIES - 1));
    end
    pick = $urandom_range(99);
    if (pick < 30) begin
      cmd = CMD_STORE_WORD;
    end else if (pick < 50) begin
      cmd = CMD_STORE_HALF;
    end else if (pick < 90) begin
      cmd = (pick < 72) ? CMD_LOAD_WORD : CMD_LOAD_HALF;
      if (written_entries.size() == 0 || $urandom_range(9) == 0) begin
        // Past the end nothing is read, so any address there is safe.
        addr = ADDR_W'($urandom_range(ADDR_TOP, MEM_ENTRIES));
        if (cmd == CMD_LOAD_WORD && $urandom_range(3) == 0) addr = ADDR_W'(MEM_ENTRIES - 1);
      end else begin
        e = written_entries[$urandom_range(written_entries.size() - 1)];
        addr = ADDR_W'(e);
        // A word load needs both of its entries defined.
        if (cmd == CMD_LOAD_WORD) begin
          if (e + 1 < MEM_ENTRIES && entry_written[e + 1]) addr = ADDR_W'(e);
          else if (e > 0 && entry_written[e - 1]) addr = ADDR_W'(e - 1);
          else cmd = CMD_LOAD_HALF;
        end
      end
    end else if (pick < 95) begin
      cmd = CMD_CLEAR;
    end else begin
      cmd = CMD_FIRST_UNUSED + CMD_W'($urandom_range(2));
    end
    send_access(cmd, addr, data);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    write_screen_base(BASE_W'($urandom_range(16'hFFFF)));
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (300) random_access();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_screen_base();
    test_random_traffic(15, 83);
    test_random_traffic(83, 15);
    test_random_traffic(0, 0);
    settle_pipeline();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/hmsf_pkg.sv
rtl/core/hmsf_ram.sv
rtl/core/halfword_memory_with_screen_flag_core.sv
test/halfword_memory_with_screen_flag_core_tb.sv
